FILE: hdl/clcid_pkg.sv
package clcid_pkg;

    localparam logic [2:0] KIND_TICK   = 3'd0;
    localparam logic [2:0] KIND_CHECK  = 3'd1;
    localparam logic [2:0] KIND_REQ    = 3'd2;
    localparam logic [2:0] KIND_ENUM   = 3'd3;
    localparam logic [2:0] KIND_REPORT = 3'd4;

    localparam logic [2:0] OUT_CHECK  = 3'd0;
    localparam logic [2:0] OUT_REQ    = 3'd1;
    localparam logic [2:0] OUT_ENUM   = 3'd2;
    localparam logic [2:0] OUT_REPORT = 3'd3;
    localparam logic [2:0] OUT_LOCAL  = 3'd4;

    localparam logic [1:0] PH_CONFIGURED = 2'd0;
    localparam logic [1:0] PH_CABLE      = 2'd1;
    localparam logic [1:0] PH_ID_RECV    = 2'd2;
    localparam logic [1:0] PH_UP         = 2'd3;

    localparam logic PORT_DOWN = 1'b0;
    localparam logic PORT_UP   = 1'b1;

    localparam logic [7:0] GOOD_BYTE = 8'hD2;
    localparam logic [7:0] NO_ID     = 8'hFF;

    localparam logic [1:0] CFG_IDX_BURST     = 2'd0;
    localparam logic [1:0] CFG_IDX_RETRY     = 2'd1;
    localparam logic [1:0] CFG_IDX_KEEPALIVE = 2'd2;

    localparam logic [7:0]  RST_BURST     = 8'd10;
    localparam logic [15:0] RST_RETRY     = 16'd100;
    localparam logic [15:0] RST_KEEPALIVE = 16'd2000;

    typedef struct packed {
        logic [7:0]  burst_checks;
        logic [15:0] retry_interval_ms;
        logic [15:0] keepalive_interval_ms;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  kind;
        logic        direction;
        logic [31:0] now_ms;
        logic [7:0]  msg_id;
        logic [15:0] pattern_bytes;
        logic [1:0]  pattern_len;
    } t_item;

    typedef struct packed {
        logic [2:0] send_kind;
        logic       send_direction;
        logic [7:0] send_id;
        logic       last;
        logic [1:0] node_phase;
        logic       node_is_master;
        logic [7:0] node_number;
    } t_result;

    typedef struct packed {
        logic       load;
        logic [1:0] count;
    } t_load;

    function automatic t_result mk_res(logic [2:0] kind, logic dir, logic [7:0] id);
        t_result r;
        r = '0;
        r.send_kind      = kind;
        r.send_direction = dir;
        r.send_id        = id;
        return r;
    endfunction

endpackage

FILE: hdl/clcid_step.sv
module clcid_step (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  clcid_pkg::t_cfg    i_cfg,
    input  clcid_pkg::t_item   i_item,
    input  logic               i_fire,
    output logic [1:0]         o_count,
    output clcid_pkg::t_result o_res0,
    output clcid_pkg::t_result o_res1
);
    import clcid_pkg::*;

    logic [1:0]  r_phase, n_phase;
    logic        r_master, n_master;
    logic [7:0]  r_node_id, n_node_id;
    logic [31:0] r_last_time, n_last_time;
    logic [1:0]  r_link_ok, n_link_ok;
    logic [15:0] r_sent, n_sent;

    logic [31:0] w_diff;
    logic        w_retry_due;
    logic        w_keep_due;
    logic        w_good;
    logic [7:0]  w_byte0;
    logic [7:0]  w_byte1;

    assign w_diff      = i_item.now_ms - r_last_time;
    assign w_retry_due = w_diff > {16'd0, i_cfg.retry_interval_ms};
    assign w_keep_due  = w_diff > {16'd0, i_cfg.keepalive_interval_ms};
    assign w_byte0     = i_item.pattern_bytes[7:0];
    assign w_byte1     = i_item.pattern_bytes[15:8];
    assign w_good      = (i_item.pattern_len == 2'd0 || w_byte0 == GOOD_BYTE)
                      && (i_item.pattern_len <= 2'd1 || w_byte1 == GOOD_BYTE);

    always_comb begin
        t_result v_r0;
        t_result v_r1;
        logic [1:0] v_n;
        v_r0        = '0;
        v_r1        = '0;
        v_n         = 2'd0;
        n_phase     = r_phase;
        n_master    = r_master;
        n_node_id   = r_node_id;
        n_last_time = r_last_time;
        n_link_ok   = r_link_ok;
        n_sent      = r_sent;
        unique case (i_item.kind)
            KIND_TICK: begin
                unique case (r_phase)
                    PH_CONFIGURED: begin
                        v_r0        = mk_res(OUT_CHECK, PORT_UP, 8'd0);
                        v_r1        = mk_res(OUT_CHECK, PORT_DOWN, 8'd0);
                        v_n         = 2'd2;
                        n_sent      = r_sent + 16'd1;
                        n_last_time = i_item.now_ms;
                        n_phase     = PH_CABLE;
                    end
                    PH_CABLE: begin
                        if (r_sent < {8'd0, i_cfg.burst_checks}) begin
                            if (w_retry_due) begin
                                v_r0        = mk_res(OUT_CHECK, PORT_UP, 8'd0);
                                v_r1        = mk_res(OUT_CHECK, PORT_DOWN, 8'd0);
                                v_n         = 2'd2;
                                n_sent      = r_sent + 16'd1;
                                n_last_time = i_item.now_ms;
                            end
                        end else if (r_link_ok[PORT_UP]) begin
                            v_r0    = mk_res(OUT_REQ, PORT_UP, 8'd0);
                            v_n     = 2'd1;
                            n_phase = PH_ID_RECV;
                        end else begin
                            n_node_id = 8'd0;
                            n_master  = 1'b1;
                            n_phase   = PH_UP;
                        end
                    end
                    PH_ID_RECV: begin
                        if (r_node_id != NO_ID) begin
                            n_phase = PH_UP;
                        end else if (w_retry_due) begin
                            v_r0        = mk_res(OUT_REQ, PORT_UP, 8'd0);
                            v_n         = 2'd1;
                            n_last_time = i_item.now_ms;
                        end
                    end
                    PH_UP: begin
                        if (w_keep_due) begin
                            v_r0        = mk_res(OUT_CHECK, PORT_UP, 8'd0);
                            v_r1        = mk_res(OUT_CHECK, PORT_DOWN, 8'd0);
                            v_n         = 2'd2;
                            n_sent      = r_sent + 16'd1;
                            n_last_time = i_item.now_ms;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            KIND_CHECK: begin
                n_link_ok[i_item.direction] = w_good;
            end
            KIND_REQ: begin
                if (i_item.direction == PORT_DOWN) begin
                    v_n = 2'd1;
                    if (r_master) begin
                        v_r0 = mk_res(OUT_ENUM, PORT_DOWN, 8'd1);
                    end else begin
                        v_r0 = mk_res(OUT_REQ, PORT_UP, 8'd0);
                    end
                end
            end
            KIND_ENUM: begin
                if (i_item.direction == PORT_UP) begin
                    n_master  = 1'b0;
                    n_node_id = i_item.msg_id;
                    v_r0      = mk_res(OUT_REPORT, PORT_UP, i_item.msg_id);
                    v_n       = 2'd1;
                    if (r_link_ok[PORT_DOWN]) begin
                        v_r1 = mk_res(OUT_ENUM, PORT_DOWN, i_item.msg_id + 8'd1);
                        v_n  = 2'd2;
                    end
                end
            end
            KIND_REPORT: begin
                v_n = 2'd1;
                if (r_master) begin
                    v_r0 = mk_res(OUT_LOCAL, PORT_DOWN, i_item.msg_id);
                end else begin
                    v_r0 = mk_res(OUT_REPORT, PORT_UP, i_item.msg_id);
                end
            end
            default: begin
            end
        endcase
        v_r0.last           = (v_n == 2'd1);
        v_r1.last           = 1'b1;
        v_r0.node_phase     = n_phase;
        v_r1.node_phase     = n_phase;
        v_r0.node_is_master = n_master;
        v_r1.node_is_master = n_master;
        v_r0.node_number    = n_node_id;
        v_r1.node_number    = n_node_id;
        o_res0  = v_r0;
        o_res1  = v_r1;
        o_count = v_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_CONFIGURED;
            r_master    <= 1'b0;
            r_node_id   <= NO_ID;
            r_last_time <= 32'd0;
            r_link_ok   <= 2'b00;
            r_sent      <= 16'd0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_master    <= n_master;
            r_node_id   <= n_node_id;
            r_last_time <= n_last_time;
            r_link_ok   <= n_link_ok;
            r_sent      <= n_sent;
        end
    end

endmodule

FILE: hdl/clcid_out_buf.sv
module clcid_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  clcid_pkg::t_load   i_load,
    input  clcid_pkg::t_result i_res0,
    input  clcid_pkg::t_result i_res1,
    input  logic               i_tready,
    output logic               o_tvalid,
    output clcid_pkg::t_result o_res,
    output logic               o_can_load
);
    import clcid_pkg::*;

    logic [1:0] r_cnt;
    t_result    r_res0;
    t_result    r_res1;
    logic       w_pop;

    assign o_tvalid   = (r_cnt != 2'd0);
    assign o_res      = r_res0;
    assign w_pop      = o_tvalid && i_tready;
    assign o_can_load = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load.load) begin
            r_cnt <= i_load.count;
        end else if (w_pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load.load) begin
            r_res0 <= i_res0;
            r_res1 <= i_res1;
        end else if (w_pop) begin
            r_res0 <= r_res1;
        end
    end

endmodule

FILE: hdl/chain_link_check_and_id_enumeration_core.sv
// channel | dir | signals                  | contents
// s_axis  | in  | tvalid tready tdata tuser | received message or millisecond tick
// m_axis  | out | tvalid tready tdata tuser | message to send or id reported locally
//         |     | tlast                     |
// cfg     | in  | we index data             | burst_checks, retry and keepalive intervals
//
// One request is taken per cycle when it yields at most one result and m_axis does not
// stall; a request with two results holds the input while the two-entry result buffer
// drains. A request is held in the input register, and its results then in the result
// buffer. Reset is synchronous and returns node state and configuration to defaults.
// A stall on m_axis fills the result buffer, then the input register, then drops tready.
module chain_link_check_and_id_enumeration_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [0] direction, [32:1] now_ms, [40:33] msg_id, [56:41] pattern_bytes,
    // [58:57] pattern_len, [63:59] zero
    input  logic [63:0] i_s_axis_tdata,
    // [2:0] kind
    input  logic [2:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [0] send_direction, [8:1] send_id, [10:9] node_phase, [11] node_is_master,
    // [19:12] node_number, [23:20] zero
    output logic [23:0] o_m_axis_tdata,
    // [2:0] send_kind
    output logic [2:0]  o_m_axis_tuser,
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import clcid_pkg::*;

    t_cfg    r_cfg;
    logic    r_in_valid;
    t_item   r_in;
    logic    w_fire;
    logic    w_accept;
    logic    w_can_load;
    logic [1:0] w_count;
    t_result w_res0;
    t_result w_res1;
    t_result w_out;
    t_load   w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.burst_checks          <= RST_BURST;
            r_cfg.retry_interval_ms     <= RST_RETRY;
            r_cfg.keepalive_interval_ms <= RST_KEEPALIVE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IDX_BURST:     r_cfg.burst_checks          <= i_cfg_data[7:0];
                CFG_IDX_RETRY:     r_cfg.retry_interval_ms     <= i_cfg_data;
                CFG_IDX_KEEPALIVE: r_cfg.keepalive_interval_ms <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_fire          = r_in_valid && (w_can_load || w_count == 2'd0);
    assign o_s_axis_tready = !r_in_valid || w_fire;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_load.load     = w_fire && (w_count != 2'd0);
    assign w_load.count    = w_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in.kind          <= i_s_axis_tuser;
            r_in.direction     <= i_s_axis_tdata[0];
            r_in.now_ms        <= i_s_axis_tdata[32:1];
            r_in.msg_id        <= i_s_axis_tdata[40:33];
            r_in.pattern_bytes <= i_s_axis_tdata[56:41];
            r_in.pattern_len   <= i_s_axis_tdata[58:57];
        end
    end

    clcid_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_item  (r_in),
        .i_fire  (w_fire),
        .o_count (w_count),
        .o_res0  (w_res0),
        .o_res1  (w_res1)
    );

    clcid_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_res0     (w_res0),
        .i_res1     (w_res1),
        .i_tready   (i_m_axis_tready),
        .o_tvalid   (o_m_axis_tvalid),
        .o_res      (w_out),
        .o_can_load (w_can_load)
    );

    assign o_m_axis_tdata = {4'd0, w_out.node_number, w_out.node_is_master,
                             w_out.node_phase, w_out.send_id, w_out.send_direction};
    assign o_m_axis_tuser = w_out.send_kind;
    assign o_m_axis_tlast = w_out.last;

endmodule
